@@ rtl/core/mee_pkg.sv @@
package mee_pkg;

    localparam int FX_BITS       = 64;
    localparam int FRAC_BITS     = 56;
    localparam int COORD_BITS    = 12;
    localparam int COUNT_BITS    = 16;
    localparam int INV_BITS      = 63;
    localparam int HALF_BITS     = FX_BITS / 2;
    localparam int PROD_BITS     = 2 * FX_BITS;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 64;

    typedef logic signed [FX_BITS-1:0] fx_t;

    localparam fx_t FX_MAX = {1'b0, {(FX_BITS-1){1'b1}}};
    localparam fx_t FX_MIN = {1'b1, {(FX_BITS-1){1'b0}}};
    localparam fx_t FOUR   = fx_t'(64'sd4 <<< FRAC_BITS);

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_RE_START,
        REG_RE_SPAN,
        REG_IM_START,
        REG_IM_SPAN,
        REG_INV_WIDTH,
        REG_INV_HEIGHT,
        REG_ITER_LIMIT
    } cfg_idx_t;

    localparam fx_t                   RST_RE_START   = -64'sd135107988821114880;
    localparam fx_t                   RST_RE_SPAN    = 64'sd270215977642229760;
    localparam fx_t                   RST_IM_START   = -64'sd81064793292668928;
    localparam fx_t                   RST_IM_SPAN    = 64'sd162129586585337856;
    localparam logic [INV_BITS-1:0]   RST_INV_WIDTH  = 63'd48038396025285;
    localparam logic [INV_BITS-1:0]   RST_INV_HEIGHT = 63'd80063993375475;
    localparam logic [COUNT_BITS-1:0] RST_ITER_LIMIT = COUNT_BITS'(200);

    typedef struct packed {
        fx_t                   re_start;
        fx_t                   re_span;
        fx_t                   im_start;
        fx_t                   im_span;
        logic [INV_BITS-1:0]   inv_width;
        logic [INV_BITS-1:0]   inv_height;
        logic [COUNT_BITS-1:0] iter_limit;
    } cfg_regs_t;

    // Request to the shared multiplier: frac_shift selects a fixed-point product
    // (shift right by FRAC_BITS) rather than an integer product.
    typedef struct packed {
        logic start;
        fx_t  a;
        fx_t  b;
        logic frac_shift;
    } mul_req_t;

    typedef struct packed {
        logic done;
        fx_t  product;
    } mul_rsp_t;

    function automatic fx_t sat_add(fx_t a, fx_t b);
        logic [FX_BITS-1:0] s;
        s = a + b;
        if ((a[FX_BITS-1] == b[FX_BITS-1]) && (s[FX_BITS-1] != a[FX_BITS-1]))
            return a[FX_BITS-1] ? FX_MIN : FX_MAX;
        return fx_t'(s);
    endfunction

    function automatic fx_t sat_sub(fx_t a, fx_t b);
        logic [FX_BITS-1:0] s;
        s = a - b;
        if ((a[FX_BITS-1] != b[FX_BITS-1]) && (s[FX_BITS-1] != a[FX_BITS-1]))
            return a[FX_BITS-1] ? FX_MIN : FX_MAX;
        return fx_t'(s);
    endfunction

endpackage

@@ rtl/core/mee_channels.sv @@
interface mee_pixel_if;
    import mee_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_col;
    logic [COORD_BITS-1:0] pixel_row;

    modport source (output valid, output pixel_col, output pixel_row, input ready);
    modport sink   (input valid, input pixel_col, input pixel_row, output ready);
endinterface

interface mee_result_if;
    import mee_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [COUNT_BITS-1:0] last_inside_step;

    modport source (output valid, output last_inside_step, input ready);
    modport sink   (input valid, input last_inside_step, output ready);
endinterface

interface mee_cfg_if;
    import mee_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/mee_cfg_regs.sv @@
module mee_cfg_regs (
    input  logic               clk,
    input  logic               rst_n,
    mee_cfg_if.sink            cfg,
    output mee_pkg::cfg_regs_t regs
);
    import mee_pkg::*;

    cfg_regs_t regs_reg;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.re_start   <= RST_RE_START;
            regs_reg.re_span    <= RST_RE_SPAN;
            regs_reg.im_start   <= RST_IM_START;
            regs_reg.im_span    <= RST_IM_SPAN;
            regs_reg.inv_width  <= RST_INV_WIDTH;
            regs_reg.inv_height <= RST_INV_HEIGHT;
            regs_reg.iter_limit <= RST_ITER_LIMIT;
        end
        else if (cfg.valid)
        begin
            // Writes to an index beyond the register list are dropped.
            case (cfg_idx_t'(cfg.index))
                REG_RE_START:   regs_reg.re_start   <= fx_t'(cfg.data);
                REG_RE_SPAN:    regs_reg.re_span    <= fx_t'(cfg.data);
                REG_IM_START:   regs_reg.im_start   <= fx_t'(cfg.data);
                REG_IM_SPAN:    regs_reg.im_span    <= fx_t'(cfg.data);
                REG_INV_WIDTH:  regs_reg.inv_width  <= cfg.data[INV_BITS-1:0];
                REG_INV_HEIGHT: regs_reg.inv_height <= cfg.data[INV_BITS-1:0];
                REG_ITER_LIMIT: regs_reg.iter_limit <= cfg.data[COUNT_BITS-1:0];
                default: ;
            endcase
        end
    end

endmodule

@@ rtl/core/mee_mul.sv @@
module mee_mul (
    input  logic              clk,
    input  logic              rst_n,
    input  mee_pkg::mul_req_t req,
    output mee_pkg::mul_rsp_t rsp
);
    import mee_pkg::*;

    logic                 busy_reg;
    logic                 fin_reg;
    logic                 done_reg;
    logic [1:0]           phase_reg;
    logic [FX_BITS-1:0]   mag_a_reg;
    logic [FX_BITS-1:0]   mag_b_reg;
    logic                 neg_reg;
    logic                 frac_reg;
    logic [PROD_BITS-1:0] acc_reg;
    fx_t                  product_reg;

    logic [FX_BITS-1:0]   mag_a;
    logic [FX_BITS-1:0]   mag_b;
    logic [HALF_BITS-1:0] half_a;
    logic [HALF_BITS-1:0] half_b;
    logic [FX_BITS-1:0]   part;
    logic [PROD_BITS-1:0] part_shifted;
    logic [FX_BITS-1:0]   mag;
    logic                 over;
    logic [FX_BITS-1:0]   limit;
    logic [FX_BITS-1:0]   clipped;
    fx_t                  product_next;

    assign mag_a = req.a[FX_BITS-1] ? (~req.a + FX_BITS'(1)) : req.a;
    assign mag_b = req.b[FX_BITS-1] ? (~req.b + FX_BITS'(1)) : req.b;

    // One 32 x 32 partial product per cycle; phase bit 0 picks the half of a,
    // bit 1 the half of b.
    assign half_a = phase_reg[0] ? mag_a_reg[FX_BITS-1:HALF_BITS] : mag_a_reg[HALF_BITS-1:0];
    assign half_b = phase_reg[1] ? mag_b_reg[FX_BITS-1:HALF_BITS] : mag_b_reg[HALF_BITS-1:0];
    assign part   = half_a * half_b;

    always_comb
    begin
        case ({phase_reg[1], phase_reg[0]})
            2'b00:   part_shifted = {{FX_BITS{1'b0}}, part};
            2'b11:   part_shifted = {part, {FX_BITS{1'b0}}};
            default: part_shifted = {{HALF_BITS{1'b0}}, part, {HALF_BITS{1'b0}}};
        endcase
    end

    always_comb
    begin
        if (frac_reg)
        begin
            mag  = acc_reg[FX_BITS+FRAC_BITS-1:FRAC_BITS];
            over = |acc_reg[PROD_BITS-1:FX_BITS+FRAC_BITS];
        end
        else
        begin
            mag  = acc_reg[FX_BITS-1:0];
            over = |acc_reg[PROD_BITS-1:FX_BITS];
        end
        // A negative result may reach one step further than a positive one.
        limit        = neg_reg ? FX_MIN : FX_MAX;
        clipped      = (over || (mag > limit)) ? limit : mag;
        product_next = neg_reg ? fx_t'(~clipped + FX_BITS'(1)) : fx_t'(clipped);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            fin_reg     <= 1'b0;
            done_reg    <= 1'b0;
            phase_reg   <= '0;
            mag_a_reg   <= '0;
            mag_b_reg   <= '0;
            neg_reg     <= 1'b0;
            frac_reg    <= 1'b0;
            acc_reg     <= '0;
            product_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            fin_reg  <= 1'b0;
            if (req.start)
            begin
                busy_reg  <= 1'b1;
                phase_reg <= '0;
                mag_a_reg <= mag_a;
                mag_b_reg <= mag_b;
                neg_reg   <= req.a[FX_BITS-1] ^ req.b[FX_BITS-1];
                frac_reg  <= req.frac_shift;
                acc_reg   <= '0;
            end
            else if (busy_reg)
            begin
                acc_reg   <= acc_reg + part_shifted;
                phase_reg <= phase_reg + 2'd1;
                if (phase_reg == 2'd3)
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
            else if (fin_reg)
            begin
                product_reg <= product_next;
                done_reg    <= 1'b1;
            end
        end
    end

    assign rsp.done    = done_reg;
    assign rsp.product = product_reg;

endmodule

@@ rtl/core/mandelbrot_escape_extended_precision.sv @@
// Channel  Dir  Handshake       Payload
// pixel    in   valid / ready   pixel_col, pixel_row
// result   out  valid / ready   last_inside_step
// cfg      in   valid / ready   index, data (register write, always ready)
//
// One shared 32 x 32 multiplier builds each 64 x 64 product in four passes.
// Mapping a pixel costs four products and each escape step three products plus
// an update. pixel.ready is low while an item is in work.
// A finished result waits in an output register, so the next item is taken
// while the result is stalled. Reset restores the default view and 200 steps.
module mandelbrot_escape_extended_precision (
    input  logic         clk,
    input  logic         rst_n,
    mee_pixel_if.sink    pixel,
    mee_result_if.source result,
    mee_cfg_if.sink      cfg
);
    import mee_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CRE_SCALE,
        S_CRE_SPAN,
        S_CIM_SCALE,
        S_CIM_SPAN,
        S_RE2,
        S_IM2,
        S_XY,
        S_UPDATE,
        S_DONE
    } state_t;

    cfg_regs_t regs;
    mul_rsp_t  mrsp;

    state_t                state_reg,     state_next;
    mul_req_t              mreq_reg,      mreq_next;
    logic [COORD_BITS-1:0] row_reg,       row_next;
    logic [COUNT_BITS-1:0] iter_reg,      iter_next;
    logic [COUNT_BITS-1:0] last_reg,      last_next;
    logic                  res_valid_reg, res_valid_next;
    logic [COUNT_BITS-1:0] res_step_reg,  res_step_next;
    fx_t                   cre_reg,       cre_next;
    fx_t                   cim_reg,       cim_next;
    fx_t                   zre_reg,       zre_next;
    fx_t                   zim_reg,       zim_next;
    fx_t                   re2_reg,       re2_next;
    fx_t                   im2_reg,       im2_next;
    fx_t                   diff_reg,      diff_next;
    fx_t                   xy2_reg,       xy2_next;

    mee_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    mee_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq_reg),
        .rsp   (mrsp)
    );

    assign pixel.ready             = (state_reg == S_IDLE);
    assign result.valid            = res_valid_reg;
    assign result.last_inside_step = res_step_reg;

    always_comb
    begin
        state_next       = state_reg;
        mreq_next        = mreq_reg;
        mreq_next.start  = 1'b0;
        row_next         = row_reg;
        iter_next        = iter_reg;
        last_next        = last_reg;
        res_valid_next   = res_valid_reg;
        res_step_next    = res_step_reg;
        cre_next         = cre_reg;
        cim_next         = cim_reg;
        zre_next         = zre_reg;
        zim_next         = zim_reg;
        re2_next         = re2_reg;
        im2_next         = im2_reg;
        diff_next        = diff_reg;
        xy2_next         = xy2_reg;

        if (result.valid && result.ready)
            res_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (pixel.valid)
                begin
                    row_next   = pixel.pixel_row;
                    mreq_next  = '{start: 1'b1, a: fx_t'(pixel.pixel_col),
                                   b: fx_t'({1'b0, regs.inv_width}), frac_shift: 1'b0};
                    state_next = S_CRE_SCALE;
                end
            end
            S_CRE_SCALE:
            begin
                if (mrsp.done)
                begin
                    mreq_next  = '{start: 1'b1, a: mrsp.product, b: regs.re_span,
                                   frac_shift: 1'b1};
                    state_next = S_CRE_SPAN;
                end
            end
            S_CRE_SPAN:
            begin
                if (mrsp.done)
                begin
                    cre_next   = sat_add(mrsp.product, regs.re_start);
                    mreq_next  = '{start: 1'b1, a: fx_t'(row_reg),
                                   b: fx_t'({1'b0, regs.inv_height}), frac_shift: 1'b0};
                    state_next = S_CIM_SCALE;
                end
            end
            S_CIM_SCALE:
            begin
                if (mrsp.done)
                begin
                    mreq_next  = '{start: 1'b1, a: mrsp.product, b: regs.im_span,
                                   frac_shift: 1'b1};
                    state_next = S_CIM_SPAN;
                end
            end
            S_CIM_SPAN:
            begin
                if (mrsp.done)
                begin
                    cim_next  = sat_add(mrsp.product, regs.im_start);
                    zre_next  = '0;
                    zim_next  = '0;
                    iter_next = '0;
                    last_next = '0;
                    // With a zero limit no step runs and the answer stays zero.
                    if (regs.iter_limit == '0)
                        state_next = S_DONE;
                    else
                    begin
                        mreq_next  = '{start: 1'b1, a: '0, b: '0, frac_shift: 1'b1};
                        state_next = S_RE2;
                    end
                end
            end
            S_RE2:
            begin
                if (mrsp.done)
                begin
                    re2_next   = mrsp.product;
                    mreq_next  = '{start: 1'b1, a: zim_reg, b: zim_reg, frac_shift: 1'b1};
                    state_next = S_IM2;
                end
            end
            S_IM2:
            begin
                if (mrsp.done)
                begin
                    im2_next = mrsp.product;
                    if (sat_add(re2_reg, mrsp.product) >= FOUR)
                        state_next = S_DONE;
                    else
                    begin
                        mreq_next  = '{start: 1'b1, a: zre_reg, b: zim_reg, frac_shift: 1'b1};
                        state_next = S_XY;
                    end
                end
            end
            S_XY:
            begin
                if (mrsp.done)
                begin
                    diff_next  = sat_sub(re2_reg, im2_reg);
                    xy2_next   = sat_add(mrsp.product, mrsp.product);
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                zre_next  = sat_add(diff_reg, cre_reg);
                zim_next  = sat_add(xy2_reg, cim_reg);
                last_next = iter_reg;
                iter_next = iter_reg + COUNT_BITS'(1);
                if (iter_reg + COUNT_BITS'(1) == regs.iter_limit)
                    state_next = S_DONE;
                else
                begin
                    mreq_next  = '{start: 1'b1, a: zre_next, b: zre_next, frac_shift: 1'b1};
                    state_next = S_RE2;
                end
            end
            S_DONE:
            begin
                // Wait only while an earlier result is still held up downstream.
                if (!res_valid_reg || result.ready)
                begin
                    res_valid_next = 1'b1;
                    res_step_next  = last_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mreq_reg      <= '0;
            row_reg       <= '0;
            iter_reg      <= '0;
            last_reg      <= '0;
            res_valid_reg <= 1'b0;
            res_step_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            mreq_reg      <= mreq_next;
            row_reg       <= row_next;
            iter_reg      <= iter_next;
            last_reg      <= last_next;
            res_valid_reg <= res_valid_next;
            res_step_reg  <= res_step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cre_reg  <= cre_next;
        cim_reg  <= cim_next;
        zre_reg  <= zre_next;
        zim_reg  <= zim_next;
        re2_reg  <= re2_next;
        im2_reg  <= im2_next;
        diff_reg <= diff_next;
        xy2_reg  <= xy2_next;
    end

endmodule

@@ rtl/core/mee_checker.sv @@
module mee_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           pixel_valid,
    input logic                           pixel_ready,
    input logic                           result_valid,
    input logic                           result_ready,
    input logic [mee_pkg::COUNT_BITS-1:0] result_step
);
    import mee_pkg::*;

    logic pixel_take;

    assign pixel_take = pixel_valid && pixel_ready;

    // The block works on one item at a time.
    assert property (@(posedge clk) disable iff (!rst_n) pixel_take |=> !pixel_ready)
        else $error("pixel taken while an item is still in work");

    // Mapping alone takes several products, so no result can appear straight away.
    assert property (@(posedge clk) disable iff (!rst_n) pixel_take |=> !$rose(result_valid))
        else $error("result raised one cycle after an item was taken");

    // The last step index is always below the largest count.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result_step != {COUNT_BITS{1'b1}}))
        else $error("step index out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=> (result_valid && $stable(result_step)))
        else $error("stalled result changed");

endmodule

bind mandelbrot_escape_extended_precision mee_checker u_mee_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .pixel_valid  (pixel.valid),
    .pixel_ready  (pixel.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_step  (result.last_inside_step)
);
